@@ rtl/utdr_pkg.sv @@
package utdr_pkg;

    // ring geometry and fifo limits
    localparam int RING_SLOTS = 8;
    localparam int FIFO_MAX   = 32;
    localparam int IDX_W      = $clog2(RING_SLOTS);

    // field widths fixed by the interface
    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 16;
    localparam int SLOT_W  = 3;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 2;

    // command codes
    localparam logic CMD_POST = 1'b0;
    localparam logic CMD_IRQ  = 1'b1;

    // result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIFO_DEPTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIFO_TRIGGER = 2'd1;

    // configuration reset values
    localparam logic [CFG_W-1:0] FIFO_DEPTH_RST   = 6'd16;
    localparam logic [CFG_W-1:0] FIFO_TRIGGER_RST = 6'd0;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] buf_addr;
        logic [LEN_W-1:0]  buf_len;
        logic              flow_hold;
    } cmd_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] byte_addr;
        logic [SLOT_W-1:0] slot;
        logic              accepted;
        logic              idle_kick;
        logic              last;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic post;
        logic report;
        logic load;
        logic step;
        logic finish;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_post;
        logic no_run;
        logic halt;
        logic rem_one;
    } ctl_sts_t;

    // ring index advance with wrap
    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(RING_SLOTS - 1)) ? '0 : i + 1'b1;
    endfunction

endpackage

@@ rtl/utdr_ctrl.sv @@
module utdr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  utdr_pkg::ctl_sts_t  sts,
    output utdr_pkg::ctl_cmd_t  ctl
);
    import utdr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_RUN    = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.is_post)
                begin
                    ctl.post   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (sts.no_run)
                begin
                    ctl.report = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                ctl.step = 1'b1;
                if (sts.halt)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.rem_one)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                ctl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ rtl/utdr_datapath.sv @@
module utdr_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  utdr_pkg::cmd_t                    cmd,
    input  logic                              wr_en,
    input  logic [utdr_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [utdr_pkg::CFG_W-1:0]        wr_data,
    input  utdr_pkg::ctl_cmd_t                ctl,
    output utdr_pkg::ctl_sts_t                sts,
    output utdr_pkg::res_t                    result,
    output logic                              result_valid
);
    import utdr_pkg::*;

    // descriptor store
    logic [ADDR_W-1:0]     slot_addr_reg  [RING_SLOTS];
    logic [ADDR_W-1:0]     slot_addr_next [RING_SLOTS];
    logic [LEN_W-1:0]      slot_count_reg [RING_SLOTS];
    logic [LEN_W-1:0]      slot_count_next[RING_SLOTS];
    logic [RING_SLOTS-1:0] slot_busy_reg;
    logic [RING_SLOTS-1:0] slot_busy_next;

    // pointers and flags
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic             idle_reg;
    logic             idle_next;

    // configuration
    logic [CFG_W-1:0] depth_reg;
    logic [CFG_W-1:0] depth_next;
    logic [CFG_W-1:0] trig_reg;
    logic [CFG_W-1:0] trig_next;

    // working copy of the tail descriptor
    cmd_t              in_reg;
    cmd_t              in_next;
    logic [ADDR_W-1:0] cur_addr_reg;
    logic [ADDR_W-1:0] cur_addr_next;
    logic [LEN_W-1:0]  cur_count_reg;
    logic [LEN_W-1:0]  cur_count_next;
    logic [CFG_W-1:0]  rem_reg;
    logic [CFG_W-1:0]  rem_next;

    // result beat register
    res_t res_reg;
    res_t res_next;
    logic res_valid_reg;
    logic res_valid_next;

    logic [CFG_W-1:0] depth_cap;
    logic [CFG_W-1:0] send_cnt;
    logic [IDX_W-1:0] tail_adv;

    // send count from fifo depth and trigger
    always_comb
    begin
        depth_cap = (depth_reg > CFG_W'(FIFO_MAX)) ? CFG_W'(FIFO_MAX) : depth_reg;
        send_cnt  = (depth_cap > trig_reg) ? depth_cap - trig_reg : '0;
        tail_adv  = next_idx(tail_reg);
    end

    // status toward the controller
    always_comb
    begin
        sts.is_post = (in_reg.command == CMD_POST);
        sts.no_run  = !slot_busy_reg[tail_reg] || in_reg.flow_hold || (send_cnt == '0);
        sts.halt    = (cur_count_reg == '0) && !slot_busy_reg[tail_adv];
        sts.rem_one = (rem_reg == CFG_W'(1));
    end

    // next state of the datapath
    always_comb
    begin
        slot_addr_next  = slot_addr_reg;
        slot_count_next = slot_count_reg;
        slot_busy_next  = slot_busy_reg;
        tail_next       = tail_reg;
        head_next       = head_reg;
        idle_next       = idle_reg;
        depth_next      = depth_reg;
        trig_next       = trig_reg;
        in_next         = in_reg;
        cur_addr_next   = cur_addr_reg;
        cur_count_next  = cur_count_reg;
        rem_next        = rem_reg;
        res_next        = res_reg;
        res_valid_next  = 1'b0;

        // configuration writes
        if (wr_en)
        begin
            if (wr_index == REG_FIFO_DEPTH)
            begin
                depth_next = wr_data;
            end
            else if (wr_index == REG_FIFO_TRIGGER)
            begin
                trig_next = wr_data;
            end
        end

        // capture input beat
        if (ctl.latch)
        begin
            in_next = cmd;
        end

        // post a descriptor at the head slot
        if (ctl.post)
        begin
            res_next           = '0;
            res_next.kind      = KIND_REPORT;
            res_next.slot      = SLOT_W'(head_reg);
            res_next.idle_kick = idle_reg;
            res_next.last      = 1'b1;
            res_valid_next     = 1'b1;
            if (!slot_busy_reg[head_reg])
            begin
                slot_addr_next[head_reg]  = in_reg.buf_addr;
                slot_count_next[head_reg] = in_reg.buf_len;
                slot_busy_next[head_reg]  = 1'b1;
                head_next                 = next_idx(head_reg);
                idle_next                 = 1'b0;
                res_next.accepted         = 1'b1;
            end
        end

        // interrupt with nothing to send
        if (ctl.report)
        begin
            res_next       = '0;
            res_next.kind  = KIND_REPORT;
            res_next.slot  = SLOT_W'(tail_reg);
            res_next.last  = 1'b1;
            res_valid_next = 1'b1;
        end

        // open the tail descriptor
        if (ctl.load)
        begin
            cur_addr_next  = slot_addr_reg[tail_reg];
            cur_count_next = slot_count_reg[tail_reg];
            rem_next       = send_cnt;
        end

        // one byte per cycle, crossing into the next slot when empty
        if (ctl.step)
        begin
            rem_next       = rem_reg - 1'b1;
            res_next       = '0;
            res_valid_next = 1'b1;
            if (cur_count_reg == '0)
            begin
                slot_busy_next[tail_reg] = 1'b0;
                tail_next                = tail_adv;
                if (!slot_busy_reg[tail_adv])
                begin
                    idle_next          = 1'b1;
                    res_next.kind      = KIND_REPORT;
                    res_next.slot      = SLOT_W'(tail_adv);
                    res_next.idle_kick = 1'b1;
                    res_next.last      = 1'b1;
                end
                else
                begin
                    res_next.kind      = KIND_BYTE;
                    res_next.byte_addr = slot_addr_reg[tail_adv];
                    res_next.slot      = SLOT_W'(tail_adv);
                    cur_addr_next      = slot_addr_reg[tail_adv] + 1'b1;
                    cur_count_next     = slot_count_reg[tail_adv] - 1'b1;
                end
            end
            else
            begin
                res_next.kind      = KIND_BYTE;
                res_next.byte_addr = cur_addr_reg;
                res_next.slot      = SLOT_W'(tail_reg);
                cur_addr_next      = cur_addr_reg + 1'b1;
                cur_count_next     = cur_count_reg - 1'b1;
            end
        end

        // write back the tail descriptor and report
        if (ctl.finish)
        begin
            slot_addr_next[tail_reg]  = cur_addr_reg;
            slot_count_next[tail_reg] = cur_count_reg;
            res_next                  = '0;
            res_next.kind             = KIND_REPORT;
            res_next.slot             = SLOT_W'(tail_reg);
            res_next.last             = 1'b1;
            res_valid_next            = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_busy_reg <= '0;
            tail_reg      <= '0;
            head_reg      <= '0;
            idle_reg      <= 1'b1;
            depth_reg     <= FIFO_DEPTH_RST;
            trig_reg      <= FIFO_TRIGGER_RST;
            rem_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            slot_busy_reg <= slot_busy_next;
            tail_reg      <= tail_next;
            head_reg      <= head_next;
            idle_reg      <= idle_next;
            depth_reg     <= depth_next;
            trig_reg      <= trig_next;
            rem_reg       <= rem_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_addr_reg  <= slot_addr_next;
        slot_count_reg <= slot_count_next;
        in_reg         <= in_next;
        cur_addr_reg   <= cur_addr_next;
        cur_count_reg  <= cur_count_next;
        res_reg        <= res_next;
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

endmodule

@@ rtl/uart_tx_descriptor_ring_drain.sv @@
// UART transmit descriptor ring drain.
// Command channel: a beat on cmd is taken at a clock edge with start high and busy
// low. A post (command 0) stores a buffer descriptor at the head slot when that
// slot is free; a transmit interrupt (command 1) drains byte addresses from the
// tail slot, up to fifo depth minus fifo trigger of them, crossing buffers.
// Result channel: each result beat sits on result for one cycle with result_valid
// high; every command ends with one report beat that has last set.
// Sequence: a post or an interrupt that sends nothing is decided after the start beat
// is taken, and its report is registered from that decision. An interrupt that sends
// N bytes loads the tail descriptor, then gives one byte per cycle and its report right
// after the last byte; at most 32 bytes. busy drops as the report goes out.
// Configuration: wr_en, wr_index, wr_data write fifo_depth (index 0) and
// fifo_trigger (index 1); other indexes are ignored. The user must write them
// only while busy is low; the block itself does not enforce this.
// Reset: all slots free, head and tail at slot 0, ring idle, depth 16, trigger 0.
// The receiver cannot stall: result beats are not held.
module uart_tx_descriptor_ring_drain (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  utdr_pkg::cmd_t                    cmd,
    input  logic                              wr_en,
    input  logic [utdr_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [utdr_pkg::CFG_W-1:0]        wr_data,
    output utdr_pkg::res_t                    result,
    output logic                              result_valid
);
    import utdr_pkg::*;

    ctl_cmd_t ctl;
    ctl_sts_t sts;

    // sequencer
    utdr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    // descriptor store and byte datapath
    utdr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .ctl          (ctl),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
